[rtl/assert_macros.svh]
// Assertion macros for the RTL of the Huber dual projection block.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HDP_ASSERT_COMB(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion %m failed");

// Check that a condition holds in the cycle after a trigger.
`define HDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion %m failed");

`endif

[rtl/hdp_pkg.sv]
// Package of the Huber dual projection block: default widths and register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hdp_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HUBER_WEIGHT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DUAL_STEP_SIZE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HUBER_EPSILON  = CFG_IDX_W'(2);

endpackage

`default_nettype wire

[rtl/hdp_div2_pipe.sv]
// Pipelined restoring divider: two unsigned dividends over one shared divisor,
// one quotient bit per stage. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hdp_div2_pipe #(
	parameter int NW = 65,
	parameter int DW = 63,
	parameter int QN = 49,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_a,
	input  logic [NW-1:0] in_b,
	input  logic [DW-1:0] in_d,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [QN-1:0] out_qa,
	output logic [QN-1:0] out_qb,
	output logic [TW-1:0] out_tag
);

	logic          v_s  [1:QN];
	logic [NW-1:0] ra_s [1:QN];
	logic [NW-1:0] rb_s [1:QN];
	logic [DW-1:0] d_s  [1:QN];
	logic [QN-1:0] qa_s [1:QN];
	logic [QN-1:0] qb_s [1:QN];
	logic [TW-1:0] t_s  [1:QN];

	for (genvar g = 0; g < QN; g++) begin : g_stage
		localparam int SH = QN - 1 - g;
		logic          v_i;
		logic [NW-1:0] ra_i, rb_i, dsh;
		logic [DW-1:0] d_i;
		logic [QN-1:0] qa_i, qb_i;
		logic [TW-1:0] t_i;
		logic          ge_a, ge_b;

		if (g == 0) begin : g_first
			assign v_i  = in_valid;
			assign ra_i = in_a;
			assign rb_i = in_b;
			assign d_i  = in_d;
			assign qa_i = '0;
			assign qb_i = '0;
			assign t_i  = in_tag;
		end else begin : g_next
			assign v_i  = v_s[g];
			assign ra_i = ra_s[g];
			assign rb_i = rb_s[g];
			assign d_i  = d_s[g];
			assign qa_i = qa_s[g];
			assign qb_i = qb_s[g];
			assign t_i  = t_s[g];
		end

		// subtract the shifted divisor only where it fits
		assign dsh  = NW'(d_i) << SH;
		assign ge_a = (ra_i >> SH) >= NW'(d_i);
		assign ge_b = (rb_i >> SH) >= NW'(d_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			ra_s[g+1] <= ge_a ? ra_i - dsh : ra_i;
			rb_s[g+1] <= ge_b ? rb_i - dsh : rb_i;
			qa_s[g+1] <= qa_i | (QN'(ge_a) << SH);
			qb_s[g+1] <= qb_i | (QN'(ge_b) << SH);
			d_s[g+1]  <= d_i;
			t_s[g+1]  <= t_i;
		end
	end

	assign out_valid = v_s[QN];
	assign out_qa    = qa_s[QN];
	assign out_qb    = qb_s[QN];
	assign out_tag   = t_s[QN];

endmodule

`default_nettype wire

[rtl/hdp_isqrt_pipe.sv]
// Pipelined integer square root (floor), one root bit per stage.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hdp_isqrt_pipe #(
	parameter int NN = 65,
	parameter int RN = 33,
	parameter int TW = 65
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NN-1:0] in_n,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [RN-1:0] out_root,
	output logic [TW-1:0] out_tag
);

	logic          v_s   [1:RN];
	logic [NN-1:0] n_s   [1:RN];
	logic [NN-1:0] res_s [1:RN];
	logic [TW-1:0] t_s   [1:RN];

	for (genvar g = 0; g < RN; g++) begin : g_stage
		localparam int BP = 2 * (RN - 1 - g);
		logic          v_i;
		logic [NN-1:0] n_i, res_i, bit_i;
		logic [TW-1:0] t_i;
		logic [NN:0]   trial;
		logic          ge;

		if (g == 0) begin : g_first
			assign v_i   = in_valid;
			assign n_i   = in_n;
			assign res_i = '0;
			assign t_i   = in_tag;
		end else begin : g_next
			assign v_i   = v_s[g];
			assign n_i   = n_s[g];
			assign res_i = res_s[g];
			assign t_i   = t_s[g];
		end

		assign bit_i = NN'(1) << BP;
		assign trial = (NN+1)'(res_i) + (NN+1)'(bit_i);
		assign ge    = (NN+1)'(n_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			n_s[g+1]   <= ge ? n_i - trial[NN-1:0] : n_i;
			res_s[g+1] <= ge ? (res_i >> 1) + bit_i : res_i >> 1;
			t_s[g+1]   <= t_i;
		end
	end

	assign out_valid = v_s[RN];
	assign out_root  = res_s[RN][RN-1:0];
	assign out_tag   = t_s[RN];

endmodule

`default_nettype wire

[rtl/huber_dual_projection_top.sv]
// Huber TV dual update and projection onto the lambda ball, signed Q(F) fixed point.
// Results leave on new_x/new_y/was_clipped with done high. One request per cycle while
//   busy is low; start is ignored while busy. Depth comes from the two bit-per-stage
//   dividers and the square root. After each configuration write busy is high while d
//   is recomputed. Reset empties the pipeline, loads lambda=1.0, sigma=1.0, epsilon=0.
//   Uses hdp_pkg and the two pipes.
`timescale 1ns / 1ps
`default_nettype none

module huber_dual_projection_top
	import hdp_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] dual_x,
	input  logic signed [DATA_WIDTH-1:0] dual_y,
	input  logic signed [DATA_WIDTH-1:0] grad_x,
	input  logic signed [DATA_WIDTH-1:0] grad_y,
	// result channel
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] new_x,
	output logic signed [DATA_WIDTH-1:0] new_y,
	output logic                         was_clipped,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_WIDTH-2:0]        cfg_data
);

	localparam int W    = DATA_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int RW   = W - 1;                       // register width
	localparam int MW   = W + ((W > F) ? W : F) + 1;   // sigma*grad + dual*2^F
	localparam int Q1   = MW - F;                      // first quotient width
	localparam int PW   = 2 * W - 2;                   // sigma*epsilon
	localparam int DQW  = 2 * W - 1;                   // divisor d in Q.F
	localparam int CNTW = $clog2(PW + 1);
	localparam int SQW  = 2 * W + 1;                   // vx^2 + vy^2
	localparam int RTW  = W + 1;                       // floor(sqrt)
	localparam int PRW  = 2 * W - 1;                   // |v| * lambda
	localparam int T3W  = 2 * W + 1;
	localparam int T4W  = 2 * W + 3;

	// ------------------------------------------------------------------
	// Configuration registers and the derived constants d and lambda^2.
	// A write lands in IDLE; MUL forms sigma*epsilon and lambda^2, DIV
	// divides sigma*epsilon by lambda one bit a cycle.
	// ------------------------------------------------------------------
	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} cfg_state_t;

	cfg_state_t       state_q;
	logic [RW-1:0]    lam_q, sig_q, eps_q;
	logic [PW-1:0]    lam2_q;
	logic [DQW-1:0]   dq_q;
	logic [PW-1:0]    div_q;
	logic [W-1:0]     rem_q;
	logic [CNTW-1:0]  cnt_q;

	logic [RW-1:0]    lam_eff;
	logic [W-1:0]     rem_sh, rem_nx;
	logic             rem_ge;

	// a zero weight acts as the smallest step
	assign lam_eff = (lam_q == '0) ? RW'(1) : lam_q;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[W-2:0], div_q[PW-1]};
	assign rem_ge = rem_sh >= {1'b0, lam_eff};
	assign rem_nx = rem_ge ? rem_sh - {1'b0, lam_eff} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lam_q   <= RW'(1) << F;
			sig_q   <= RW'(1) << F;
			eps_q   <= '0;
			lam2_q  <= PW'(1) << (2 * F);
			dq_q    <= DQW'(1) << F;
			div_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_HUBER_WEIGHT:   lam_q <= cfg_data;
							REG_DUAL_STEP_SIZE: sig_q <= cfg_data;
							REG_HUBER_EPSILON:  eps_q <= cfg_data;
							default: ;  // drop writes beyond the register list
						endcase
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					div_q   <= PW'(sig_q) * PW'(eps_q);
					lam2_q  <= PW'(lam_eff) * PW'(lam_eff);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					div_q <= {div_q[PW-2:0], rem_ge};
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(PW - 1)) begin
						// d = 1.0 + floor(sigma*epsilon / lambda)
						dq_q    <= (DQW'(1) << F) + DQW'({div_q[PW-2:0], rem_ge});
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// ------------------------------------------------------------------
	// Stage 1: sigma*grad products, dual scaled to Q.2F.
	// ------------------------------------------------------------------
	logic                  acc;
	logic                  v_s1;
	logic signed [2*W-1:0] prodx_s1, prody_s1;
	logic signed [MW-1:0]  dxs_s1, dys_s1;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		prodx_s1 <= $signed({1'b0, sig_q}) * grad_x;
		prody_s1 <= $signed({1'b0, sig_q}) * grad_y;
		dxs_s1   <= MW'(dual_x) <<< F;
		dys_s1   <= MW'(dual_y) <<< F;
	end

	// ------------------------------------------------------------------
	// Stage 2: sum, then split into sign and magnitude for the divider.
	// ------------------------------------------------------------------
	logic signed [MW-1:0] sumx, sumy;
	logic                 v_s2, negx_s2, negy_s2;
	logic [MW-1:0]        magx_s2, magy_s2;

	assign sumx = MW'(prodx_s1) + dxs_s1;
	assign sumy = MW'(prody_s1) + dys_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		negx_s2 <= sumx[MW-1];
		negy_s2 <= sumy[MW-1];
		magx_s2 <= sumx[MW-1] ? MW'(-sumx) : MW'(sumx);
		magy_s2 <= sumy[MW-1] ? MW'(-sumy) : MW'(sumy);
	end

	// ------------------------------------------------------------------
	// Divide by d: one quotient bit per stage.
	// ------------------------------------------------------------------
	logic          d1_v;
	logic [Q1-1:0] d1_qa, d1_qb;
	logic [1:0]    d1_tag;

	hdp_div2_pipe #(
		.NW (MW),
		.DW (DQW),
		.QN (Q1),
		.TW (2)
	) u_div_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_a      (magx_s2),
		.in_b      (magy_s2),
		.in_d      (dq_q),
		.in_tag    ({negx_s2, negy_s2}),
		.out_valid (d1_v),
		.out_qa    (d1_qa),
		.out_qb    (d1_qb),
		.out_tag   (d1_tag)
	);

	// restore the sign and saturate to the output range
	function automatic logic signed [W-1:0] sat_q1(input logic [Q1-1:0] q, input logic neg);
		logic [Q1-1:0] lim_p;
		logic [Q1-1:0] lim_n;
		lim_p = Q1'({(W-1){1'b1}});
		lim_n = Q1'(1) << (W - 1);
		if (!neg) begin
			return (q > lim_p) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
		end
		return (q >= lim_n) ? {1'b1, {(W-1){1'b0}}} : W'(-q[W-1:0]);
	endfunction

	// ------------------------------------------------------------------
	// Stage 3: saturated v.
	// ------------------------------------------------------------------
	logic                v_s3;
	logic signed [W-1:0] vx_s3, vy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		vx_s3 <= sat_q1(d1_qa, d1_tag[1]);
		vy_s3 <= sat_q1(d1_qb, d1_tag[0]);
	end

	// ------------------------------------------------------------------
	// Stage 4: squares of |v|.
	// ------------------------------------------------------------------
	logic [W-1:0]        ax3, ay3;
	logic                v_s4;
	logic [2*W-1:0]      sqx_s4, sqy_s4;
	logic signed [W-1:0] vx_s4, vy_s4;

	assign ax3 = vx_s3[W-1] ? W'(-vx_s3) : W'(vx_s3);
	assign ay3 = vy_s3[W-1] ? W'(-vy_s3) : W'(vy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s4 <= (2*W)'(ax3) * (2*W)'(ax3);
		sqy_s4 <= (2*W)'(ay3) * (2*W)'(ay3);
		vx_s4  <= vx_s3;
		vy_s4  <= vy_s3;
	end

	// ------------------------------------------------------------------
	// Stage 5: |v|^2 and the clip decision against lambda^2.
	// ------------------------------------------------------------------
	logic [SQW-1:0]      mag2;
	logic                v_s5, clip_s5;
	logic [SQW-1:0]      mag2_s5;
	logic signed [W-1:0] vx_s5, vy_s5;

	assign mag2 = SQW'(sqx_s4) + SQW'(sqy_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		mag2_s5 <= mag2;
		clip_s5 <= mag2 > SQW'(lam2_q);
		vx_s5   <= vx_s4;
		vy_s5   <= vy_s4;
	end

	// ------------------------------------------------------------------
	// r = floor(sqrt(|v|^2)), one root bit per stage.
	// ------------------------------------------------------------------
	logic           rt_v;
	logic [RTW-1:0] rt_root;
	logic [T3W-1:0] rt_tag;

	hdp_isqrt_pipe #(
		.NN (SQW),
		.RN (RTW),
		.TW (T3W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_n      (mag2_s5),
		.in_tag    ({vx_s5, vy_s5, clip_s5}),
		.out_valid (rt_v),
		.out_root  (rt_root),
		.out_tag   (rt_tag)
	);

	// ------------------------------------------------------------------
	// Stage 6: |v| * lambda for the projection.
	// ------------------------------------------------------------------
	logic signed [W-1:0] rvx, rvy;
	logic [W-1:0]        ax6, ay6;
	logic                v_s6;
	logic [PRW-1:0]      px_s6, py_s6;
	logic [RTW-1:0]      root_s6;
	logic [T4W-1:0]      tag_s6;

	assign rvx = rt_tag[2*W:W+1];
	assign rvy = rt_tag[W:1];
	assign ax6 = rvx[W-1] ? W'(-rvx) : W'(rvx);
	assign ay6 = rvy[W-1] ? W'(-rvy) : W'(rvy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		px_s6   <= PRW'(ax6) * PRW'(lam_eff);
		py_s6   <= PRW'(ay6) * PRW'(lam_eff);
		root_s6 <= rt_root;
		tag_s6  <= {rvx[W-1], rvy[W-1], rt_tag};
	end

	// ------------------------------------------------------------------
	// Divide by r; unused for vectors inside the ball.
	// ------------------------------------------------------------------
	logic           d2_v;
	logic [W-1:0]   d2_qa, d2_qb;
	logic [T4W-1:0] d2_tag;

	hdp_div2_pipe #(
		.NW (PRW),
		.DW (RTW),
		.QN (W),
		.TW (T4W)
	) u_div_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_a      (px_s6),
		.in_b      (py_s6),
		.in_d      (root_s6),
		.in_tag    (tag_s6),
		.out_valid (d2_v),
		.out_qa    (d2_qa),
		.out_qb    (d2_qb),
		.out_tag   (d2_tag)
	);

	// ------------------------------------------------------------------
	// Output register: projected or pass-through vector, one-cycle strobe.
	// Projected components stay within lambda, so no saturation here.
	// ------------------------------------------------------------------
	logic                o_negx, o_negy, o_clip;
	logic signed [W-1:0] o_vx, o_vy;

	assign o_negx = d2_tag[T4W-1];
	assign o_negy = d2_tag[T4W-2];
	assign o_vx   = d2_tag[2*W:W+1];
	assign o_vy   = d2_tag[W:1];
	assign o_clip = d2_tag[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		new_x       <= o_clip ? (o_negx ? W'(-d2_qa) : d2_qa) : o_vx;
		new_y       <= o_clip ? (o_negy ? W'(-d2_qb) : d2_qb) : o_vy;
		was_clipped <= o_clip;
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`include "assert_macros.svh"

	// every accepted write must start a recompute of d
	`HDP_ASSERT_NEXT(a_cfg_recalc, cfg_valid && cfg_ready, busy)
	// a clipped vector has a root no smaller than the radius
	`HDP_ASSERT_COMB(a_root_covers_radius, !(rt_v && rt_tag[0]) || (rt_root >= RTW'(lam_eff)))
	// the x component of a clipped result stays within lambda
	`HDP_ASSERT_COMB(a_clip_in_ball, !(done && was_clipped) || ((new_x[W-1] ? W'(-new_x) : W'(new_x)) <= W'(lam_eff)))

endmodule

`default_nettype wire
